/* rtl/core/brbap_pkg.sv */
`default_nettype none

package brbap_pkg;

  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned MAX_BURST_DEF = 16;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned MAXR_W  = 5;
  localparam int unsigned RKIND_W = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned FILL_W  = 8;
  localparam int unsigned FREE_W  = 9;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [RKIND_W-1:0] RST_READ  = 2'd0;
  localparam logic [RKIND_W-1:0] RST_WRITE = 2'd1;

  localparam logic [KIND_W-1:0] KIND_WSTAT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RDONE = 2'd3;

  typedef struct packed {
    logic accept;
    logic pop;
  } dp_cmd_t;

  typedef struct packed {
    logic now_result;
    logic burst_go;
    logic last_pop;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/brbap_ctrl.sv */
`default_nettype none

module brbap_ctrl
  import brbap_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  wire logic     m_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_BURST = 1'b1;

  logic state_q, state_d;
  logic vld_q, vld_d;
  logic slot_free;
  logic load;

  assign slot_free = !vld_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE) && slot_free;
  assign m_valid_o = vld_q;

  always_comb begin
    cmd_o.accept = s_valid_i && s_ready_o;
    cmd_o.pop    = (state_q == ST_BURST) && slot_free;
    state_d      = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && stat_i.burst_go) begin
          state_d = ST_BURST;
        end
      end
      ST_BURST: begin
        if (cmd_o.pop && stat_i.last_pop) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    load = (cmd_o.accept && stat_i.now_result) || cmd_o.pop;
    if (load) begin
      vld_d = 1'b1;
    end else if (m_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BURST) |-> !s_ready_o)
    else $error("input taken during a read burst");
  a_burst_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop && stat_i.last_pop) |=> (state_q == ST_IDLE))
    else $error("burst did not end after its last byte");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !m_ready_i) |=> vld_q)
    else $error("pending result dropped");
`endif

endmodule

`default_nettype wire

/* rtl/core/brbap_dp.sv */
`default_nettype none

module brbap_dp
  import brbap_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output dp_stat_t                stat_o,
  input  wire logic [CMD_W-1:0]   cmd_in_i,
  input  wire logic [BYTE_W-1:0]  data_byte_i,
  input  wire logic               run_start_i,
  input  wire logic [LEN_W-1:0]   run_length_i,
  input  wire logic [MAXR_W-1:0]  max_read_i,
  input  wire logic [RKIND_W-1:0] reset_kind_i,
  output logic [KIND_W-1:0]       kind_o,
  output logic [BYTE_W-1:0]       read_data_o,
  output logic                    rejected_o,
  output logic                    last_o,
  output logic [FILL_W-1:0]       fill_level_o,
  output logic [FREE_W-1:0]       free_space_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(MAX_BURST + 1);
  localparam int unsigned FW0   = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;
  localparam int unsigned FW    = (FW0 > MAXR_W) ? FW0 : MAXR_W;
  localparam int unsigned MW    = (FW > CNT_W) ? FW : CNT_W;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d, sp_q, sp_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [KIND_W-1:0] kind_q, kind_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              rej_q, rej_d, last_q, last_d;
  logic [FILL_W-1:0] fill_q;
  logic [FREE_W-1:0] free_q;

  logic [PTR_W-1:0] fill_c, fill_n;
  logic [FW-1:0]    free_w, fill_nw, free_nw;
  logic [MW-1:0]    n_a, n_b;
  logic             mem_we;
  logic [PTR_W-1:0] mem_wa;
  logic             out_ld;

  assign fill_c = wp_q - rp_q;
  assign free_w = FW'(DEPTH) - FW'(fill_c);

  // burst size: smallest of request, burst limit and fill level
  always_comb begin
    n_a = (MW'(max_read_i) < MW'(MAX_BURST)) ? MW'(max_read_i) : MW'(MAX_BURST);
    n_b = (MW'(fill_c) < n_a) ? MW'(fill_c) : n_a;
  end

  always_comb begin
    stat_o.burst_go   = (cmd_in_i == CMD_READ) && (n_b != '0);
    stat_o.now_result = (cmd_in_i != CMD_NONE) && !stat_o.burst_go;
    stat_o.last_pop   = (cnt_q == CNT_W'(1));
  end

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    sp_d   = sp_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    mem_we = 1'b0;
    mem_wa = sp_q;
    kind_d = KIND_WSTAT;
    data_d = '0;
    rej_d  = 1'b0;
    last_d = 1'b1;
    if (cmd_i.accept) begin
      case (cmd_in_i)
        CMD_WRITE: begin
          if (run_start_i) begin
            if (FW'(run_length_i) < free_w) begin
              acc_d = 1'b1;
              sp_d  = wp_q;
              rem_d = run_length_i;
            end else begin
              acc_d = 1'b0;
              rem_d = '0;
            end
          end
          if (acc_d && (rem_d != '0)) begin
            mem_we = 1'b1;
            mem_wa = sp_d;
            sp_d   = sp_d + PTR_W'(1);
            rem_d  = rem_d - LEN_W'(1);
            if (rem_d == '0) begin
              wp_d  = sp_d;
              acc_d = 1'b0;
            end
          end else if (acc_d) begin
            acc_d = 1'b0;
          end else begin
            rej_d = 1'b1;
          end
        end
        CMD_READ: begin
          kind_d = KIND_EMPTY;
          cnt_d  = n_b[CNT_W-1:0];
        end
        CMD_RESET: begin
          kind_d = KIND_RDONE;
          if (reset_kind_i != RST_WRITE) begin
            rp_d = '0;
          end
          if (reset_kind_i != RST_READ) begin
            wp_d  = '0;
            acc_d = 1'b0;
            rem_d = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.pop) begin
      kind_d = KIND_DATA;
      data_d = rdata_q;
      last_d = stat_o.last_pop;
      rp_d   = rp_q + PTR_W'(1);
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  assign out_ld  = (cmd_i.accept && stat_o.now_result) || cmd_i.pop;
  assign fill_n  = wp_d - rp_d;
  assign fill_nw = FW'(fill_n);
  assign free_nw = FW'(DEPTH) - fill_nw;

  // storage, read port follows the next read pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= data_byte_i;
    end
    rdata_q <= mem_q[rp_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      sp_q  <= '0;
      rem_q <= '0;
      acc_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      sp_q  <= sp_d;
      rem_q <= rem_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      kind_q <= kind_d;
      data_q <= data_d;
      rej_q  <= rej_d;
      last_q <= last_d;
      fill_q <= fill_nw[FILL_W-1:0];
      free_q <= free_nw[FREE_W-1:0];
    end
  end

  assign kind_o       = kind_q;
  assign read_data_o  = data_q;
  assign rejected_o   = rej_q;
  assign last_o       = last_q;
  assign fill_level_o = fill_q;
  assign free_space_o = free_q;

`ifndef NO_ASSERTIONS
  a_open_run_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q |-> (rem_q != '0))
    else $error("open run with no bytes left");
  a_pop_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (cnt_q != '0))
    else $error("burst byte taken with zero count");
  a_burst_loads_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && stat_o.burst_go) |=> (cnt_q != '0))
    else $error("burst started without a count");
`endif

endmodule

`default_nettype wire

/* rtl/core/byte_ring_buffer_atomic_put_unit.sv */
`default_nettype none

// Byte ring buffer with all-or-nothing write runs. Each write item carries one
// byte; a run's first item gives its length and the run is dropped unless it
// fits below the free space, and stored bytes only become readable when the
// run's last byte arrives. A read burst holds the input until its last byte
// is taken: the accepted read item starts the registered read of the storage,
// then one byte moves out per cycle while the output is taken. Results wait
// in a single output register, so a new item is accepted only when that
// register is empty or is being taken in the same cycle. Storage needs no
// clearing after reset.
module byte_ring_buffer_atomic_put_unit
  import brbap_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // data_byte, run_length, max_read
  input  wire logic [4:0]  s_axis_tuser,  // cmd, run_start, reset_kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // read_data, fill_level, free_space
  output logic [2:0]       m_axis_tuser,  // kind, rejected
  output logic             m_axis_tlast
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] read_data;
  logic              rejected;
  logic [FILL_W-1:0] fill_level;
  logic [FREE_W-1:0] free_space;

  brbap_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  brbap_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .cmd_in_i     (s_axis_tuser[1:0]),
    .data_byte_i  (s_axis_tdata[7:0]),
    .run_start_i  (s_axis_tuser[2]),
    .run_length_i (s_axis_tdata[16:8]),
    .max_read_i   (s_axis_tdata[21:17]),
    .reset_kind_i (s_axis_tuser[4:3]),
    .kind_o       (kind),
    .read_data_o  (read_data),
    .rejected_o   (rejected),
    .last_o       (m_axis_tlast),
    .fill_level_o (fill_level),
    .free_space_o (free_space)
  );

  assign m_axis_tdata = {7'd0, free_space, fill_level, read_data};
  assign m_axis_tuser = {rejected, kind};

endmodule

`default_nettype wire

/* tb/sv/byte_ring_buffer_atomic_put_unit_test.sv */
`default_nettype none

module byte_ring_buffer_atomic_put_unit_test;
  import brbap_pkg::*;

  localparam logic [RKIND_W-1:0] RST_BOTH     = 2'd2;
  localparam logic [RKIND_W-1:0] RST_BOTH_ALT = 2'd3;
  localparam int unsigned ITEMS  = 360;
  localparam int unsigned SETTLE = 40;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  data_byte;
    logic               run_start;
    logic [LEN_W-1:0]   run_length;
    logic [MAXR_W-1:0]  max_read;
    logic [RKIND_W-1:0] reset_kind;
  } req_t;

  typedef struct packed {
    req_t rq;
    logic drain;
  } stim_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] read_data;
    logic              rejected;
    logic              last;
    logic [FILL_W-1:0] fill;
    logic [FREE_W-1:0] space;
  } res_t;

  typedef struct packed {
    logic [DEPTH_DEF-1:0][BYTE_W-1:0] mem;
    logic [DEPTH_DEF-1:0]             written;
    logic [FILL_W-1:0]                wptr;
    logic [FILL_W-1:0]                rptr;
    logic [FILL_W-1:0]                sptr;
    logic [LEN_W-1:0]                 remain;
    logic                             run_ok;
  } ring_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // data_byte, run_length, max_read
  logic [4:0]  s_axis_tuser  = '0;  // cmd, run_start, reset_kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // read_data, fill_level, free_space
  logic [2:0]  m_axis_tuser;        // kind, rejected
  logic        m_axis_tlast;

  ring_t plan_ring = '0;
  ring_t ring      = '0;
  stim_t stim_q[$];
  res_t  want_q[$];
  stim_t cur;
  req_t  live_rq   = '0;
  res_t  got;
  res_t  want;
  int    planned   = 0;
  int    total     = 1;
  int    shown_n   = 0;
  int    took_n    = 0;
  int    errors    = 0;

  byte_ring_buffer_atomic_put_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic res_t mk_res(input ring_t st, input logic [KIND_W-1:0] k,
                                  input logic [BYTE_W-1:0] d, input logic rej,
                                  input logic lst);
    res_t r;
    r.kind      = k;
    r.read_data = d;
    r.rejected  = rej;
    r.last      = lst;
    r.fill      = st.wptr - st.rptr;
    r.space     = FREE_W'(DEPTH_DEF - r.fill);
    return r;
  endfunction

  function automatic void ring_step(ref ring_t st, input req_t rq, ref res_t outs[$]);
    logic [FILL_W-1:0] fill;
    logic [FREE_W-1:0] room;
    logic [BYTE_W-1:0] byte_v;
    logic              rej;
    int                n;
    int                k;
    fill = st.wptr - st.rptr;
    case (rq.cmd)
      CMD_WRITE: begin
        rej = 1'b0;
        if (rq.run_start) begin
          room = FREE_W'(DEPTH_DEF - fill);
          if (rq.run_length < room) begin
            st.run_ok = 1'b1;
            st.sptr   = st.wptr;
            st.remain = rq.run_length;
          end else begin
            st.run_ok = 1'b0;
            st.remain = '0;
          end
        end
        if (st.run_ok && st.remain != 0) begin
          st.mem[st.sptr]     = rq.data_byte;
          st.written[st.sptr] = 1'b1;
          st.sptr             = st.sptr + 1'b1;
          st.remain           = st.remain - 1'b1;
          if (st.remain == 0) begin
            st.wptr   = st.sptr;
            st.run_ok = 1'b0;
          end
        end else if (st.run_ok) begin
          st.run_ok = 1'b0;
        end else begin
          rej = 1'b1;
        end
        outs.push_back(mk_res(st, KIND_WSTAT, '0, rej, 1'b1));
      end
      CMD_READ: begin
        n = rq.max_read;
        if (n > MAX_BURST_DEF) n = MAX_BURST_DEF;
        if (n > fill) n = fill;
        if (n == 0) begin
          outs.push_back(mk_res(st, KIND_EMPTY, '0, 1'b0, 1'b1));
        end else begin
          for (k = 0; k < n; k++) begin
            byte_v  = st.mem[st.rptr];
            st.rptr = st.rptr + 1'b1;
            outs.push_back(mk_res(st, KIND_DATA, byte_v, 1'b0, k == n - 1));
          end
        end
      end
      CMD_RESET: begin
        if (rq.reset_kind != RST_WRITE) st.rptr = '0;
        if (rq.reset_kind != RST_READ) begin
          st.wptr   = '0;
          st.run_ok = 1'b0;
          st.remain = '0;
        end
        outs.push_back(mk_res(st, KIND_RDONE, '0, 1'b0, 1'b1));
      end
      default: begin
      end
    endcase
  endfunction

  function automatic req_t noise(input logic [CMD_W-1:0] c);
    req_t rq;
    rq.cmd        = c;
    rq.data_byte  = BYTE_W'($urandom_range(255));
    rq.run_start  = 1'($urandom_range(1));
    rq.run_length = LEN_W'($urandom_range(511));
    rq.max_read   = MAXR_W'($urandom_range(31));
    rq.reset_kind = RKIND_W'($urandom_range(3));
    return rq;
  endfunction

  function automatic req_t wr(input logic st, input int len, input int d);
    req_t rq;
    rq           = noise(CMD_WRITE);
    rq.run_start = st;
    rq.data_byte = BYTE_W'(d);
    if (st) rq.run_length = LEN_W'(len);
    return rq;
  endfunction

  function automatic req_t rd(input int m);
    req_t rq;
    rq          = noise(CMD_READ);
    rq.max_read = MAXR_W'(m);
    return rq;
  endfunction

  function automatic req_t rs(input logic [RKIND_W-1:0] rk);
    req_t rq;
    rq            = noise(CMD_RESET);
    rq.reset_kind = rk;
    return rq;
  endfunction

  // bursts are trimmed so that no never-written entry is read
  task automatic plan(input req_t rq, input logic drain);
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] idx;
    int                n;
    int                w;
    res_t              sink[$];
    if (rq.cmd == CMD_READ) begin
      fill = plan_ring.wptr - plan_ring.rptr;
      n = rq.max_read;
      if (n > MAX_BURST_DEF) n = MAX_BURST_DEF;
      if (n > fill) n = fill;
      w   = 0;
      idx = plan_ring.rptr;
      while (w < n && plan_ring.written[idx]) begin
        w++;
        idx = idx + 1'b1;
      end
      if (w < n) rq.max_read = MAXR_W'(w);
    end
    ring_step(plan_ring, rq, sink);
    stim_q.push_back({rq, drain});
    if (rq.cmd != CMD_NONE) planned++;
  endtask

  task automatic run(input int len, input int sent, input logic drain);
    int i;
    for (i = 0; i < sent; i++) begin
      if (i > 0 && $urandom_range(99) < 8) plan(rd($urandom_range(31)), 1'b0);
      plan(wr(i == 0, len, $urandom_range(255)), drain && i == 0);
    end
  endtask

  initial begin
    int pick;
    int sz;
    int len;
    int sent;
    int hold_mark;
    int stop_at;
    logic drain;

    plan(rd(5), 1'b0);
    plan(wr(1'b1, 0, 8'h11), 1'b0);
    plan(wr(1'b0, 0, 8'h22), 1'b0);
    plan(wr(1'b1, 256, 8'h33), 1'b0);
    plan(wr(1'b0, 0, 8'h44), 1'b0);
    plan(wr(1'b1, 3, 8'h00), 1'b0);
    plan(wr(1'b0, 0, 8'hFF), 1'b0);
    plan(wr(1'b0, 0, 8'hA5), 1'b0);
    plan(wr(1'b1, 2, 8'h12), 1'b0);
    plan(wr(1'b0, 0, 8'h34), 1'b0);
    plan(wr(1'b1, 1, 8'h5A), 1'b0);
    plan(rd(0), 1'b0);
    plan(rd(31), 1'b0);
    plan(wr(1'b1, 3, 8'h81), 1'b0);
    plan(rs(RST_READ), 1'b0);
    plan(wr(1'b0, 0, 8'h7E), 1'b0);
    plan(wr(1'b0, 0, 8'hC3), 1'b0);
    plan(rd(16), 1'b0);
    plan(wr(1'b1, 2, 8'h01), 1'b0);
    plan(rs(RST_WRITE), 1'b0);
    plan(wr(1'b0, 0, 8'h02), 1'b0);
    plan(rs(RST_BOTH_ALT), 1'b0);
    plan(rs(RST_BOTH), 1'b0);
    plan(noise(CMD_NONE), 1'b0);
    plan(wr(1'b1, 255, 8'hEE), 1'b0);
    plan(wr(1'b0, 0, 8'h99), 1'b0);

    hold_mark = planned;
    stop_at   = planned + ITEMS;
    while (planned < stop_at) begin
      drain = planned >= hold_mark;
      if (drain) hold_mark = hold_mark + ITEMS / 3;
      pick = $urandom_range(99);
      if (pick < 45) begin
        sz = $urandom_range(99);
        if (sz < 75) len = $urandom_range(8, 1);
        else if (sz < 88) len = $urandom_range(40, 17);
        else if (sz < 94) len = 0;
        else len = $urandom_range(511, 41);
        if (len == 0) sent = 1;
        else if (len <= 40 && $urandom_range(9) != 0) sent = len;
        else sent = $urandom_range(len < 6 ? len : 6, 1);
        run(len, sent, drain);
      end else if (pick < 75) begin
        plan(rd($urandom_range(31)), drain);
      end else if (pick < 84) begin
        plan(wr(1'b0, 0, $urandom_range(255)), drain);
      end else if (pick < 92) begin
        plan(rs(RKIND_W'($urandom_range(3))), drain);
      end else begin
        plan(noise(CMD_NONE), drain);
      end
    end
    total = planned;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (stim_q.size() != 0 || took_n != shown_n) @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && want_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // sender
  always @(negedge clk_i) begin
    int stage;
    logic idle;
    stage = (took_n * 3) / total;
    if (stage == 0) idle = $urandom_range(99) < 22;
    else if (stage == 1) idle = $urandom_range(99) < 48;
    else idle = 1'b0;
    if (rst_ni && took_n == shown_n) begin
      if (stim_q.size() != 0 && !idle && !(stim_q[0].drain && want_q.size() != 0)) begin
        cur = stim_q.pop_front();
        live_rq = cur.rq;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cur.rq.max_read, cur.rq.run_length, cur.rq.data_byte};
        s_axis_tuser  <= {cur.rq.reset_kind, cur.rq.run_start, cur.rq.cmd};
        shown_n++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    int stage;
    stage = (took_n * 3) / total;
    if (stage == 0) m_axis_tready <= $urandom_range(99) >= 48;
    else if (stage == 1) m_axis_tready <= $urandom_range(99) >= 22;
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        ring_step(ring, live_rq, want_q);
        took_n++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = m_axis_tuser[1:0];
        got.rejected  = m_axis_tuser[2];
        got.read_data = m_axis_tdata[7:0];
        got.fill      = m_axis_tdata[15:8];
        got.space     = m_axis_tdata[24:16];
        got.last      = m_axis_tlast;
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item kind %0d data %h fill %0d", $time, got.kind,
                   got.read_data, got.fill);
        end else begin
          want = want_q.pop_front();
          if (got.kind !== want.kind || got.read_data !== want.read_data ||
              got.rejected !== want.rejected || got.last !== want.last ||
              got.fill !== want.fill || got.space !== want.space) begin
            errors++;
            $display({"%0t: mismatch expected kind %0d data %h rej %b last %b fill %0d ",
                      "free %0d, actual kind %0d data %h rej %b last %b fill %0d free %0d"},
                     $time, want.kind, want.read_data, want.rejected, want.last, want.fill,
                     want.space, got.kind, got.read_data, got.rejected, got.last, got.fill,
                     got.space);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/brbap_pkg.sv
rtl/core/brbap_ctrl.sv
rtl/core/brbap_dp.sv
rtl/core/byte_ring_buffer_atomic_put_unit.sv
tb/sv/byte_ring_buffer_atomic_put_unit_test.sv
